>>> rtl/gwm_pkg.sv
// Shared types and constants for the glob wildcard matcher.
// Used by gwm_step and glob_wildcard_matcher_core; no dependencies.
package gwm_pkg;

  localparam int MAX_PATTERN_BYTES = 16;
  localparam int LEN_W             = $clog2(MAX_PATTERN_BYTES + 1);
  localparam int VEC_W             = MAX_PATTERN_BYTES + 1;
  localparam int CFG_DATA_W        = 64;
  localparam int CFG_IDX_W         = 2;

  localparam logic [7:0] STAR_BYTE     = 8'h2A;
  localparam logic [7:0] QUESTION_BYTE = 8'h3F;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAT_LOW  = 2'd0,
    REG_PAT_HIGH = 2'd1,
    REG_PAT_LEN  = 2'd2
  } cfg_reg_t;

  // byte 0 of the pattern sits in the lowest bits
  typedef logic [MAX_PATTERN_BYTES-1:0][7:0] pat_t;
  typedef logic [VEC_W-1:0]                  vec_t;

endpackage

>>> rtl/gwm_step.sv
// One-byte update of the active pattern position vector, with star closure.
// Depends on gwm_pkg.
module gwm_step
  import gwm_pkg::*;
(
  input  pat_t             pattern,
  input  logic [LEN_W-1:0] pat_len,
  input  vec_t             state,
  input  logic [7:0]       text_byte,
  input  logic             has_byte,
  output vec_t             nxt_state,
  output logic             matched
);

  logic [LEN_W-1:0]             n;
  vec_t                         keep;
  logic [MAX_PATTERN_BYTES-1:0] star;
  logic [MAX_PATTERN_BYTES-1:0] in_use;
  vec_t                         cur;
  vec_t                         raw;

  // bit j is reached from a set bit i <= j when bytes i..j-1 are all stars
  function automatic vec_t closure(vec_t v, logic [MAX_PATTERN_BYTES-1:0] st);
    vec_t res;
    logic term;
    res = '0;
    for (int j = 0; j < VEC_W; j++) begin
      for (int i = 0; i <= j; i++) begin
        term = v[i];
        for (int k = i; k < j; k++) begin
          term = term & st[k];
        end
        res[j] = res[j] | term;
      end
    end
    return res;
  endfunction

  always_comb begin
    n = (pat_len > LEN_W'(MAX_PATTERN_BYTES)) ? LEN_W'(MAX_PATTERN_BYTES) : pat_len;
    for (int j = 0; j < VEC_W; j++) begin
      keep[j] = (LEN_W'(j) <= n);
    end
    for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
      in_use[i] = (LEN_W'(i) < n);
      star[i]   = in_use[i] && (pattern[i] == STAR_BYTE);
    end
  end

  always_comb begin
    cur = closure(state & keep, star);
    raw = '0;
    for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
      if (cur[i] && in_use[i]) begin
        if (star[i]) begin
          raw[i] = 1'b1;
        end
        if (star[i] || pattern[i] == QUESTION_BYTE || pattern[i] == text_byte) begin
          raw[i+1] = 1'b1;
        end
      end
    end
    nxt_state = has_byte ? closure(raw & keep, star) : cur;
    matched   = nxt_state[n];
  end

endmodule

>>> rtl/glob_wildcard_matcher_core.sv
// Top level of the glob wildcard matcher: stream ports, pattern registers,
// input and result registers. Depends on gwm_pkg and gwm_step.
//
// Matches each text, streamed one byte per item, against a glob pattern of up
// to 16 bytes where '*' matches any run (also empty) and '?' any single byte.
// One item is taken every clock cycle unless stalled; an item with tuser low
// carries no byte and, alone, stands for an empty text. The item with tlast
// high yields one result, the match bit in bit 0 of out_tdata, via input and
// result registers. A final item waits in the input register while an earlier
// result is held by out_tready low, and the input side stalls with it. The
// rate comes from a single registered update of a 17-bit vector of active
// pattern positions per byte. Pattern registers must be written through the
// cfg port while no item is in flight, not enforced; cfg_ready is always high.
module glob_wildcard_matcher_core
  import gwm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] text_byte
  input  logic                  in_tuser,   // [0] has_byte
  input  logic                  in_tlast,   // last_byte
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [7:0]            out_tdata,  // [0] matched, [7:1] zero
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [CFG_DATA_W-1:0] pat_low_r;
  logic [CFG_DATA_W-1:0] pat_high_r;
  logic [LEN_W-1:0]      pat_len_r;
  vec_t                  state_r;
  logic                  in_valid_r;
  logic [7:0]            in_byte_r;
  logic                  in_has_r;
  logic                  in_last_r;
  logic                  out_valid_r;
  logic                  out_match_r;

  pat_t pattern;
  vec_t step_nxt;
  logic step_match;
  logic out_free;
  logic advance;

  assign pattern   = {pat_high_r, pat_low_r};
  assign out_free  = !out_valid_r || out_tready;
  // non-final items never need the result register
  assign advance   = in_valid_r && (!in_last_r || out_free);
  assign in_tready = !in_valid_r || advance;
  assign cfg_ready = 1'b1;

  gwm_step u_step (
    .pattern   (pattern),
    .pat_len   (pat_len_r),
    .state     (state_r),
    .text_byte (in_byte_r),
    .has_byte  (in_has_r),
    .nxt_state (step_nxt),
    .matched   (step_match)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_low_r  <= '0;
      pat_high_r <= '0;
      pat_len_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PAT_LOW:  pat_low_r  <= cfg_data;
        REG_PAT_HIGH: pat_high_r <= cfg_data;
        REG_PAT_LEN:  pat_len_r  <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_has_r  <= in_tuser;
      in_last_r <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= VEC_W'(1);
    end else if (advance) begin
      // rearm at position zero after the final item of a text
      state_r <= in_last_r ? VEC_W'(1) : step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && in_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last_r) begin
      out_match_r <= step_match;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_match_r};

endmodule

>>> rtl/gwm_checker.sv
// Port-level checks for glob_wildcard_matcher_core, attached by bind.
// Depends on gwm_pkg.
module gwm_checker
  import gwm_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [7:0]            out_tdata,
  input logic                  cfg_ready
);

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed or dropped while stalled");

  // input side only stalls behind a stalled result
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without a pending result");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[7:1] == 7'b0)
    else $error("result padding bits not zero");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("configuration port not ready");

endmodule

bind glob_wildcard_matcher_core gwm_checker u_gwm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .cfg_ready  (cfg_ready)
);

>>> dv/gwm_match_checker.sv
// Scoreboard for glob_wildcard_matcher_core: watches the cfg, input and result
// channels, predicts each match bit and compares. Depends on gwm_pkg.
module gwm_match_checker
  import gwm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] text_byte
  input  logic                  in_tuser,   // [0] has_byte
  input  logic                  in_tlast,   // last_byte
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [7:0]            out_tdata,  // [0] matched, [7:1] zero
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending_results
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [63:0] pat_lo_q;
  logic [63:0] pat_hi_q;
  logic [4:0]  pat_len_q;
  vec_t        live_pos;
  logic        match_q[$];
  int          results_seen;

  task automatic flag_mismatch(input string msg);
    $display("%0t gwm_match_checker: %s", $time, msg);
    fail_count++;
  endtask

  // a live position sitting on a star also makes the next position live
  function automatic vec_t close_stars(vec_t v, pat_t p, int n);
    for (int i = 0; i < VEC_W; i++)
      if (i > n) v[i] = 1'b0;
    for (int i = 0; i < n; i++)
      if (v[i] && p[i] == STAR_BYTE) v[i+1] = 1'b1;
    return v;
  endfunction

  function automatic vec_t next_positions(vec_t v, pat_t p, int n, logic has,
                                          logic [7:0] b);
    vec_t cur;
    vec_t nxt;
    cur = close_stars(v, p, n);
    if (!has) return cur;
    nxt = '0;
    for (int i = 0; i < n; i++) begin
      if (cur[i]) begin
        if (p[i] == STAR_BYTE) nxt[i] = 1'b1;
        if (p[i] == STAR_BYTE || p[i] == QUESTION_BYTE || p[i] == b) nxt[i+1] = 1'b1;
      end
    end
    return close_stars(nxt, p, n);
  endfunction

  always @(posedge clk) begin
    int   n;
    vec_t nxt;
    logic want;
    if (!rst_n) begin
      pat_lo_q     = '0;
      pat_hi_q     = '0;
      pat_len_q    = '0;
      live_pos     = vec_t'(1);
      results_seen = 0;
      fail_count   = 0;
      match_q.delete();
      pending_results <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_PAT_LOW:  pat_lo_q  = cfg_data;
          REG_PAT_HIGH: pat_hi_q  = cfg_data;
          REG_PAT_LEN:  pat_len_q = cfg_data[4:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (match_q.size() == 0) begin
          flag_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
        end else begin
          want = match_q.pop_front();
          if (out_tdata[0] !== want)
            flag_mismatch($sformatf("result %0d matched=%b, expected %b",
                                    results_seen, out_tdata[0], want));
          if (out_tdata[7:1] !== 7'd0)
            flag_mismatch($sformatf("result %0d padding bits %b not zero",
                                    results_seen, out_tdata[7:1]));
        end
      end
      if (in_tvalid && in_tready) begin
        n   = (pat_len_q > MAX_PATTERN_BYTES) ? MAX_PATTERN_BYTES : int'(pat_len_q);
        nxt = next_positions(live_pos, pat_t'({pat_hi_q, pat_lo_q}), n, in_tuser, in_tdata);
        if (in_tlast) begin
          match_q.push_back(nxt[n]);
          live_pos = vec_t'(1);
        end else begin
          live_pos = nxt;
        end
      end
      pending_results <= match_q.size();
    end
  end

endmodule

>>> dv/glob_wildcard_matcher_core_tb.sv
// Testbench top for glob_wildcard_matcher_core: clock, reset, pattern loads
// and text stimulus; checking lives in gwm_match_checker. Depends on gwm_pkg.
module glob_wildcard_matcher_core_tb;
  import gwm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 6;
  localparam int TOTAL_ITEMS  = 1800;
  localparam int CALM_ITEMS   = 1500;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata = '0;   // [7:0] text_byte
  logic                  in_tuser = 1'b0; // [0] has_byte
  logic                  in_tlast = 1'b0; // last_byte
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [7:0]            out_tdata;       // [0] matched, [7:1] zero
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    fail_count;
  int                    pending_results;

  bit          calm = 1'b0;
  pat_t        cur_pat;
  int          cur_n;
  logic [7:0]  text_q[$];
  int          items_sent = 0;

  glob_wildcard_matcher_core uut (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser, .in_tlast,
    .out_tvalid, .out_tready, .out_tdata,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  gwm_match_checker chk (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser, .in_tlast,
    .out_tvalid, .out_tready, .out_tdata,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .fail_count, .pending_results
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #4_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // result side back-pressure
  initial begin
    @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  function automatic logic [7:0] any_byte();
    if ($urandom_range(0, 1) == 0) return 8'h61 + 8'($urandom_range(0, 2));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic pat_t random_pattern();
    pat_t p;
    for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2:    p[i] = STAR_BYTE;
        3:          p[i] = QUESTION_BYTE;
        4, 5, 6, 7: p[i] = 8'h61 + 8'($urandom_range(0, 2));
        default:    p[i] = 8'($urandom_range(0, 255));
      endcase
    end
    return p;
  endfunction

  task automatic push_item(input logic [7:0] b, input logic has, input logic is_last);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= has;
    in_tlast  <= is_last;
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  // hold the sender until every match bit is back and the pipe is empty
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_pattern(input pat_t p, input logic [63:0] len_word);
    logic [127:0] flat;
    flat = p;
    settle();
    write_reg(REG_PAT_LOW, flat[63:0]);
    write_reg(REG_PAT_HIGH, flat[127:64]);
    write_reg(REG_PAT_LEN, len_word);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // mostly texts shaped after the pattern, some damaged, some pure noise
  task automatic build_text();
    int pos;
    text_q.delete();
    if ($urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(0, 10)) text_q.push_back(any_byte());
    end else begin
      for (int i = 0; i < cur_n; i++) begin
        if (cur_pat[i] == STAR_BYTE)
          repeat ($urandom_range(0, 3)) text_q.push_back(any_byte());
        else if (cur_pat[i] == QUESTION_BYTE)
          text_q.push_back(any_byte());
        else
          text_q.push_back(cur_pat[i]);
      end
      if ($urandom_range(0, 3) == 0) begin
        pos = (text_q.size() == 0) ? 0 : $urandom_range(0, text_q.size() - 1);
        case ($urandom_range(0, 2))
          0: if (text_q.size() != 0) text_q[pos] = any_byte();
          1: if (text_q.size() != 0) text_q.delete(pos);
          default: text_q.insert(pos, any_byte());
        endcase
      end
    end
  endtask

  task automatic send_text();
    logic tail_blank;
    tail_blank = ($urandom_range(0, 5) == 0);
    for (int k = 0; k < text_q.size(); k++) begin
      if ($urandom_range(0, 11) == 0) push_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      push_item(text_q[k], 1'b1, (k == text_q.size() - 1) && !tail_blank);
    end
    if (text_q.size() == 0 || tail_blank) push_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  initial begin
    pat_t        p;
    logic [4:0]  len5;
    logic [63:0] len_word;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty pattern after reset: only the empty text matches
    push_item(8'h00, 1'b0, 1'b1);
    push_item(8'h00, 1'b1, 1'b1);

    // all stars, length word far above the maximum, then a stray register write
    load_pattern({MAX_PATTERN_BYTES{STAR_BYTE}}, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_UNUSED, 64'h0);
    cfg_valid <= 1'b0;
    @(posedge clk);
    push_item(8'hFF, 1'b1, 1'b1);
    push_item(8'h00, 1'b0, 1'b1);

    // zero byte as a literal followed by a question mark
    p = '0;
    p[1] = QUESTION_BYTE;
    load_pattern(p, 64'd2);
    push_item(8'h00, 1'b1, 1'b0);
    push_item(8'hFF, 1'b1, 1'b1);
    push_item(8'h01, 1'b1, 1'b0);
    push_item(8'h00, 1'b1, 1'b1);

    // question mark in the top byte of the high register
    p = {MAX_PATTERN_BYTES{STAR_BYTE}};
    p[15] = QUESTION_BYTE;
    load_pattern(p, 64'd16);
    push_item(8'h00, 1'b0, 1'b1);
    push_item(8'h80, 1'b1, 1'b1);

    // pattern shortened in the middle of a text
    p = '0;
    p[0] = 8'h61;
    p[1] = 8'h62;
    load_pattern(p, 64'd2);
    push_item(8'h61, 1'b1, 1'b0);
    settle();
    write_reg(REG_PAT_LEN, 64'd1);
    cfg_valid <= 1'b0;
    @(posedge clk);
    push_item(8'h00, 1'b0, 1'b1);
    cur_pat = p;

    while (items_sent < TOTAL_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       len5 = 5'd0;
        1:       len5 = 5'd16;
        2:       len5 = 5'($urandom_range(17, 31));
        default: len5 = 5'($urandom_range(1, ($urandom_range(0, 3) == 0) ? 16 : 8));
      endcase
      len_word = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : 64'd0;
      len_word[4:0] = len5;
      if ($urandom_range(0, 3) != 0) begin
        cur_pat = random_pattern();
        load_pattern(cur_pat, len_word);
      end else begin
        settle();
        write_reg(REG_PAT_LEN, len_word);
        cfg_valid <= 1'b0;
        @(posedge clk);
      end
      cur_n = (len5 > MAX_PATTERN_BYTES) ? MAX_PATTERN_BYTES : int'(len5);
      calm  = (items_sent >= CALM_ITEMS);
      repeat ($urandom_range(6, 14)) begin
        build_text();
        send_text();
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
